// ===== rtl/mbcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mbcl_pkg
// Shared types and constants of the multi-button click / long-press detector.
// ----------------------------------------------------------------------------
package mbcl_pkg;

  // default sizing
  localparam int NUM_BUTTONS_DEF       = 6;
  localparam int TICK_COUNTER_BITS_DEF = 16;

  // fixed field widths
  localparam int LEVELS_W = 6;
  localparam int COUNT_W  = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd5;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd300;
  localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd30;
  localparam logic [CFG_W-1:0] CEILING_RST    = 16'hFFFF;

  typedef struct packed {
    logic [LEVELS_W-1:0] pressed_levels;
    logic                clear_events;
  } in_word_t;

  typedef struct packed {
    logic [LEVELS_W-1:0] click_mask;
    logic [LEVELS_W-1:0] long_mask;
    logic                multi_click;
    logic [COUNT_W-1:0]  pressed_count;
  } out_word_t;

  // thresholds seen by every lane
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] click_gap_ticks;
  } thresh_t;

  // per-lane status after the update
  typedef struct packed {
    logic click;
    logic long_press;
    logic multi;
  } lane_status_t;

endpackage

// ===== rtl/mbcl_lane.sv =====
// ----------------------------------------------------------------------------
// mbcl_lane
// One button: tick counters, phase machine, event and extra-press count.
// ----------------------------------------------------------------------------
module mbcl_lane #(
  parameter int CNT_W = mbcl_pkg::TICK_COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  pressed,
  input  logic                  clear,
  input  mbcl_pkg::thresh_t     thresh,
  input  logic [CNT_W-1:0]      ceiling,
  output mbcl_pkg::lane_status_t status
);

  localparam int CMP_W = (CNT_W > mbcl_pkg::CFG_W) ? CNT_W : mbcl_pkg::CFG_W;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_DOWN  = 3'd1,
    PH_UP    = 3'd2,
    PH_COUNT = 3'd3,
    PH_LONG  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  phase_t           phase_r, phase_nxt;
  event_t           event_r, event_nxt;
  logic [7:0]       extra_r, extra_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] idle_r, idle_nxt;

  logic [CMP_W-1:0] held_cmp, idle_cmp;

  always_comb begin
    event_nxt = clear ? EV_NONE : event_r;
    extra_nxt = clear ? 8'd0 : extra_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    idle_nxt  = idle_r;
    if (pressed) begin
      idle_nxt = '0;
      if (held_r < ceiling) begin
        held_nxt = held_r + 1'b1;
      end
    end else begin
      held_nxt = '0;
      if (idle_r < ceiling) begin
        idle_nxt = idle_r + 1'b1;
      end
    end
    held_cmp = CMP_W'(held_nxt);
    idle_cmp = CMP_W'(idle_nxt);
    if (pressed) begin
      case (phase_r)
        PH_IDLE: begin
          if (held_cmp > CMP_W'(thresh.debounce_ticks)) phase_nxt = PH_DOWN;
        end
        PH_DOWN: begin
          if (held_cmp > CMP_W'(thresh.long_press_ticks)) begin
            phase_nxt = PH_LONG;
            event_nxt = EV_LONG;
          end
        end
        PH_UP: begin
          if (held_cmp > CMP_W'(thresh.debounce_ticks)) begin
            phase_nxt = PH_COUNT;
            event_nxt = EV_NONE;
            extra_nxt = extra_nxt + 8'd1;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase_r)
        PH_DOWN: phase_nxt = PH_UP;
        PH_UP: begin
          if (idle_cmp > CMP_W'(thresh.click_gap_ticks)) begin
            phase_nxt = PH_IDLE;
            event_nxt = EV_CLICK;
          end
        end
        PH_COUNT: begin
          phase_nxt = PH_UP;
          event_nxt = EV_NONE;
        end
        PH_LONG: begin
          phase_nxt = PH_IDLE;
          event_nxt = EV_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      event_r <= EV_NONE;
      extra_r <= 8'd0;
      held_r  <= '0;
      idle_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      event_r <= event_nxt;
      extra_r <= extra_nxt;
      held_r  <= held_nxt;
      idle_r  <= idle_nxt;
    end
  end

  // status of the state this step leaves behind
  assign status.click      = (event_nxt == EV_CLICK);
  assign status.long_press = (event_nxt == EV_LONG);
  assign status.multi      = (extra_nxt != 8'd0);

endmodule

// ===== rtl/mbcl_merge.sv =====
// ----------------------------------------------------------------------------
// mbcl_merge
// Gathers lane status into the result word.
// ----------------------------------------------------------------------------
module mbcl_merge #(
  parameter int NUM_BUTTONS = mbcl_pkg::NUM_BUTTONS_DEF
) (
  input  mbcl_pkg::lane_status_t            status [NUM_BUTTONS],
  input  logic [mbcl_pkg::LEVELS_W-1:0]     levels,
  output mbcl_pkg::out_word_t               result
);

  localparam int SHOWN = (NUM_BUTTONS < mbcl_pkg::LEVELS_W) ? NUM_BUTTONS
                                                             : mbcl_pkg::LEVELS_W;

  logic [NUM_BUTTONS-1:0]           multi_bits;
  logic [mbcl_pkg::LEVELS_W-1:0]    click_bits, long_bits, live_levels;
  logic [mbcl_pkg::COUNT_W-1:0]     count;

  genvar g;
  generate
    for (g = 0; g < NUM_BUTTONS; g++) begin : g_multi
      assign multi_bits[g] = status[g].multi;
    end
    for (g = 0; g < mbcl_pkg::LEVELS_W; g++) begin : g_mask
      if (g < SHOWN) begin : g_live
        assign click_bits[g]  = status[g].click;
        assign long_bits[g]   = status[g].long_press;
        assign live_levels[g] = levels[g];
      end else begin : g_dead
        assign click_bits[g]  = 1'b0;
        assign long_bits[g]   = 1'b0;
        assign live_levels[g] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    count = '0;
    for (int i = 0; i < mbcl_pkg::LEVELS_W; i++) begin
      count = count + mbcl_pkg::COUNT_W'(live_levels[i]);
    end
  end

  assign result.click_mask    = click_bits;
  assign result.long_mask     = long_bits;
  assign result.multi_click   = |multi_bits;
  assign result.pressed_count = count;

endmodule

// ===== rtl/multi_button_click_long_press_detector.sv =====
// ----------------------------------------------------------------------------
// multi_button_click_long_press_detector
// Per-button click, multi-click and long-press detection, one tick per word.
// ----------------------------------------------------------------------------
// Each input word is one sampling tick of all buttons and produces exactly one
// result word. A word is taken every clock cycle while in_stall is low: every
// button has its own lane (counters plus phase machine) that updates in the
// cycle of acceptance, and a merge stage builds the masks and count for the
// output register, so the tick-to-tick dependence needs no extra register.
// Results land in the output register, or in the skid entry while it stalls;
// in_stall rises only once both are full, so a tick can be taken while an
// earlier result waits. The user must write thresholds and counter ceiling
// through the cfg port only with no tick in flight; the block does not check.
module multi_button_click_long_press_detector #(
  parameter int NUM_BUTTONS       = mbcl_pkg::NUM_BUTTONS_DEF,
  parameter int TICK_COUNTER_BITS = mbcl_pkg::TICK_COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mbcl_pkg::in_word_t              in_data,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output mbcl_pkg::out_word_t             out_data,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mbcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbcl_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int CNT_W = TICK_COUNTER_BITS;
  localparam int CMP_W = (CNT_W > mbcl_pkg::CFG_W) ? CNT_W : mbcl_pkg::CFG_W;
  localparam logic [CMP_W-1:0] CNT_FULL = CMP_W'({CNT_W{1'b1}});

  // configuration registers
  mbcl_pkg::thresh_t            thresh_r;
  logic [mbcl_pkg::CFG_W-1:0]   ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.debounce_ticks   <= mbcl_pkg::DEBOUNCE_RST;
      thresh_r.long_press_ticks <= mbcl_pkg::LONG_PRESS_RST;
      thresh_r.click_gap_ticks  <= mbcl_pkg::CLICK_GAP_RST;
      ceiling_r                 <= mbcl_pkg::CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mbcl_pkg::REG_DEBOUNCE:   thresh_r.debounce_ticks   <= cfg_wdata;
        mbcl_pkg::REG_LONG_PRESS: thresh_r.long_press_ticks <= cfg_wdata;
        mbcl_pkg::REG_CLICK_GAP:  thresh_r.click_gap_ticks  <= cfg_wdata;
        mbcl_pkg::REG_CEILING:    ceiling_r                 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ceiling clipped to what the counters can hold
  logic [CMP_W-1:0] ceiling_wide;
  logic [CNT_W-1:0] ceiling_eff;
  assign ceiling_wide = (CMP_W'(ceiling_r) < CNT_FULL) ? CMP_W'(ceiling_r) : CNT_FULL;
  assign ceiling_eff  = ceiling_wide[CNT_W-1:0];

  // handshake
  logic                 out_valid_r, skid_valid_r;
  mbcl_pkg::out_word_t  out_data_r, skid_data_r;
  logic                 accept, take, slot_free;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid_r && !out_stall;
  assign slot_free = !out_valid_r || take;

  // lanes: buttons past the input width read as released
  mbcl_pkg::lane_status_t lane_status [NUM_BUTTONS];
  mbcl_pkg::out_word_t    result;

  genvar g;
  generate
    for (g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      logic lane_pressed;
      if (g < mbcl_pkg::LEVELS_W) begin : g_in
        assign lane_pressed = in_data.pressed_levels[g];
      end else begin : g_off
        assign lane_pressed = 1'b0;
      end
      mbcl_lane #(
        .CNT_W (CNT_W)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .pressed (lane_pressed),
        .clear   (in_data.clear_events),
        .thresh  (thresh_r),
        .ceiling (ceiling_eff),
        .status  (lane_status[g])
      );
    end
  endgenerate

  mbcl_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .status (lane_status),
    .levels (in_data.pressed_levels),
    .result (result)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (slot_free) begin
      // skid entry drains first; in_stall keeps accept low meanwhile
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (!slot_free && accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry only ever holds a word behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  // skid fills only when the output word was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled while output was free");

  // an accepted tick always yields a pending word next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted tick left no result");

  // a button cannot hold click and long press at once
  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.click_mask & out_data_r.long_mask) == '0))
    else $error("click and long-press masks overlap");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-button click / long-press detector. A
// queue of tick words feeds a clocked driver; a clocked monitor checks every
// result word against a cycle-free model of the per-button phase machines.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NB          = mbcl_pkg::NUM_BUTTONS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // per-button phase and action codes of the model
  typedef enum logic [2:0] {
    BTN_IDLE, BTN_DOWN, BTN_UP, BTN_COUNTING, BTN_LONG_HELD
  } btn_phase_t;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_CLICK, ACT_LONG
  } btn_action_t;

  // one pending tick; drain_first holds it back until every result is in
  typedef struct {
    mbcl_pkg::in_word_t word;
    bit                 drain_first;
  } tick_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  mbcl_pkg::in_word_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  mbcl_pkg::out_word_t            out_data;
  logic                           cfg_we = 1'b0;
  logic [mbcl_pkg::CFG_IDX_W-1:0] cfg_index = mbcl_pkg::REG_DEBOUNCE;
  logic [mbcl_pkg::CFG_W-1:0]     cfg_wdata = '0;

  tick_entry_t         tick_queue[$];
  mbcl_pkg::out_word_t predicted_reports[$];
  tick_entry_t         drv_entry;
  mbcl_pkg::out_word_t seen_expected;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // model copy of the registers
  logic [mbcl_pkg::CFG_W-1:0] m_debounce;
  logic [mbcl_pkg::CFG_W-1:0] m_long_press;
  logic [mbcl_pkg::CFG_W-1:0] m_click_gap;
  logic [mbcl_pkg::CFG_W-1:0] m_ceiling;

  // model copy of the per-button state
  btn_phase_t  lane_phase  [NB];
  logic [15:0] held_cnt    [NB];
  logic [15:0] idle_cnt    [NB];
  btn_action_t lane_action [NB];
  logic [7:0]  extra_cnt   [NB];

  multi_button_click_long_press_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // advance the button model by one tick and build the result word
  function automatic mbcl_pkg::out_word_t predict_tick(mbcl_pkg::in_word_t w);
    mbcl_pkg::out_word_t r;
    int b;
    r = '0;
    // clear acts before the tick is processed
    if (w.clear_events) begin
      for (b = 0; b < NB; b++) begin
        lane_action[b] = ACT_NONE;
        extra_cnt[b] = 8'd0;
      end
    end
    for (b = 0; b < NB; b++) begin
      if (w.pressed_levels[b]) begin
        r.pressed_count = r.pressed_count + 3'd1;
        // saturate at the ceiling; a value already above it just holds
        if (held_cnt[b] < m_ceiling) held_cnt[b] = held_cnt[b] + 16'd1;
        idle_cnt[b] = 16'd0;
        case (lane_phase[b])
          BTN_IDLE: begin
            if (held_cnt[b] > m_debounce) lane_phase[b] = BTN_DOWN;
          end
          BTN_DOWN: begin
            if (held_cnt[b] > m_long_press) begin
              lane_phase[b] = BTN_LONG_HELD;
              lane_action[b] = ACT_LONG;
            end
          end
          BTN_UP: begin
            // another press inside the release gap
            if (held_cnt[b] > m_debounce) begin
              lane_phase[b] = BTN_COUNTING;
              lane_action[b] = ACT_NONE;
              extra_cnt[b] = extra_cnt[b] + 8'd1;
            end
          end
          default: ;
        endcase
      end else begin
        if (idle_cnt[b] < m_ceiling) idle_cnt[b] = idle_cnt[b] + 16'd1;
        held_cnt[b] = 16'd0;
        case (lane_phase[b])
          BTN_DOWN: lane_phase[b] = BTN_UP;
          BTN_UP: begin
            if (idle_cnt[b] > m_click_gap) begin
              lane_phase[b] = BTN_IDLE;
              lane_action[b] = ACT_CLICK;
            end
          end
          BTN_COUNTING: begin
            lane_phase[b] = BTN_UP;
            lane_action[b] = ACT_NONE;
          end
          BTN_LONG_HELD: begin
            lane_phase[b] = BTN_IDLE;
            lane_action[b] = ACT_NONE;
          end
          default: ;
        endcase
      end
    end
    for (b = 0; b < NB; b++) begin
      r.click_mask[b] = (lane_action[b] == ACT_CLICK);
      r.long_mask[b]  = (lane_action[b] == ACT_LONG);
      if (extra_cnt[b] != 8'd0) r.multi_click = 1'b1;
    end
    return r;
  endfunction

  // driver: presents queued words, idling at random, and predicts on accept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_reports.push_back(predict_tick(in_data));
      // a held word stays put; only a free slot takes the next one
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 &&
            !(tick_queue[0].drain_first && (predicted_reports.size() != 0 || out_valid)) &&
            $urandom_range(99) >= send_idle_pct) begin
          drv_entry = tick_queue.pop_front();
          in_valid <= 1'b1;
          in_data <= drv_entry.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure and field-by-field check of each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          $error("result word %h arrived with no prediction waiting", out_data);
          mismatches++;
        end else begin
          seen_expected = predicted_reports.pop_front();
          if (out_data.click_mask !== seen_expected.click_mask) begin
            $error("click_mask: expected %0h, got %0h",
                   seen_expected.click_mask, out_data.click_mask);
            mismatches++;
          end
          if (out_data.long_mask !== seen_expected.long_mask) begin
            $error("long_mask: expected %0h, got %0h",
                   seen_expected.long_mask, out_data.long_mask);
            mismatches++;
          end
          if (out_data.multi_click !== seen_expected.multi_click) begin
            $error("multi_click: expected %0h, got %0h",
                   seen_expected.multi_click, out_data.multi_click);
            mismatches++;
          end
          if (out_data.pressed_count !== seen_expected.pressed_count) begin
            $error("pressed_count: expected %0d, got %0d",
                   seen_expected.pressed_count, out_data.pressed_count);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // register writes seen on the port update the model copy
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_index)
        mbcl_pkg::REG_DEBOUNCE:   m_debounce = cfg_wdata;
        mbcl_pkg::REG_LONG_PRESS: m_long_press = cfg_wdata;
        mbcl_pkg::REG_CLICK_GAP:  m_click_gap = cfg_wdata;
        mbcl_pkg::REG_CEILING:    m_ceiling = cfg_wdata;
        default: ;
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_tick(input logic [mbcl_pkg::LEVELS_W-1:0] levels, input logic clr);
    tick_entry_t e;
    e.word.pressed_levels = levels;
    e.word.clear_events = clr;
    e.drain_first = 1'b0;
    tick_queue.push_back(e);
  endtask

  // all four registers back to back, then the enable drops
  task automatic program_regs(input logic [mbcl_pkg::CFG_W-1:0] deb,
                              input logic [mbcl_pkg::CFG_W-1:0] lng,
                              input logic [mbcl_pkg::CFG_W-1:0] gap,
                              input logic [mbcl_pkg::CFG_W-1:0] ceil);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mbcl_pkg::REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= mbcl_pkg::REG_LONG_PRESS;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_index <= mbcl_pkg::REG_CLICK_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= mbcl_pkg::REG_CEILING;
    cfg_wdata <= ceil;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every queued word is accepted and answered
  task automatic wait_drained();
    while (tick_queue.size() != 0 || predicted_reports.size() != 0 || in_valid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // press and release runs per button with random lengths around the
  // thresholds; some words are pure noise and a few wait for a full drain
  task automatic queue_button_runs(input int n, input int hold_max, input int rel_max);
    logic [mbcl_pkg::LEVELS_W-1:0] lvl;
    int run_left [NB];
    tick_entry_t e;
    int k, b;
    lvl = '0;
    for (b = 0; b < NB; b++) run_left[b] = $urandom_range(rel_max, 1);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 12) begin
        e.word.pressed_levels = mbcl_pkg::LEVELS_W'($urandom);
      end else begin
        for (b = 0; b < NB; b++) begin
          if (run_left[b] == 0) begin
            lvl[b] = ~lvl[b];
            run_left[b] = lvl[b] ? $urandom_range(hold_max, 1) : $urandom_range(rel_max, 1);
          end
          run_left[b]--;
        end
        e.word.pressed_levels = lvl;
      end
      e.word.clear_events = ($urandom_range(99) < 4);
      e.drain_first = ($urandom_range(99) < 2);
      tick_queue.push_back(e);
    end
  endtask

  initial begin
    int p, deb, lng, gap, ceil, hold_max, rel_max;
    // model starts from the reset state
    m_debounce = mbcl_pkg::DEBOUNCE_RST;
    m_long_press = mbcl_pkg::LONG_PRESS_RST;
    m_click_gap = mbcl_pkg::CLICK_GAP_RST;
    m_ceiling = mbcl_pkg::CEILING_RST;
    for (int b = 0; b < NB; b++) begin
      lane_phase[b] = BTN_IDLE;
      held_cnt[b] = 16'd0;
      idle_cnt[b] = 16'd0;
      lane_action[b] = ACT_NONE;
      extra_cnt[b] = 8'd0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero debounce, short long press and gap, no idling
    program_regs(16'd0, 16'd2, 16'd1, 16'hFFFF);
    push_tick(6'h3F, 1'b0);   // all buttons down
    push_tick(6'h3F, 1'b0);
    push_tick(6'h3F, 1'b0);   // long press on all
    push_tick(6'h00, 1'b0);   // long-held back to idle
    push_tick(6'h01, 1'b0);
    push_tick(6'h00, 1'b0);   // down to up
    push_tick(6'h01, 1'b0);   // extra press inside the gap
    push_tick(6'h00, 1'b0);
    push_tick(6'h00, 1'b0);   // gap runs out, click
    push_tick(6'h00, 1'b1);   // clear with nothing pressed
    push_tick(6'h2A, 1'b0);
    push_tick(6'h15, 1'b1);   // clear while pressed
    push_tick(6'h3F, 1'b0);
    push_tick(6'h3F, 1'b0);   // leave counters nonzero for the ceiling drop
    wait_drained();

    // extremes: ceiling lowered under live counters, thresholds at maximum
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h00, 1'b0);
    push_tick(6'h15, 1'b1);
    push_tick(6'h2A, 1'b0);
    wait_drained();

    // tiny ceiling caps the counters right at the thresholds
    program_regs(16'd2, 16'd2, 16'd0, 16'd3);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h3F, 1'b0);
    push_tick(6'h3F, 1'b0);   // press accepted at the cap
    push_tick(6'h3F, 1'b0);   // long press at the cap
    push_tick(6'h00, 1'b0);
    push_tick(6'h00, 1'b0);
    wait_drained();

    // random phases, cycling through the idling modes
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      deb = $urandom_range(3);
      lng = $urandom_range(12);
      gap = $urandom_range(6);
      ceil = 16'hFFFF;
      if (p == 0) begin
        deb = 0; lng = 0; gap = 0;
      end else if (p == 3) begin
        deb = 5; lng = 40; gap = 10;
      end else if (p == 5) begin
        ceil = $urandom_range(9, 2);
      end else if (p == 7) begin
        deb = 1; lng = 16'hFFFF; gap = 3;
      end
      program_regs(mbcl_pkg::CFG_W'(deb), mbcl_pkg::CFG_W'(lng),
                   mbcl_pkg::CFG_W'(gap), mbcl_pkg::CFG_W'(ceil));
      hold_max = (lng + deb + 6 > 48) ? 48 : lng + deb + 6;
      rel_max = (gap + 6 > 48) ? 48 : gap + 6;
      queue_button_runs(112, hold_max, rel_max);
      wait_drained();
    end

    repeat (16) @(negedge clk);
    mismatches += predicted_reports.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mbcl_pkg.sv
rtl/mbcl_lane.sv
rtl/mbcl_merge.sv
rtl/multi_button_click_long_press_detector.sv
verif/testbench.sv
